>>> hw/rtl/tcg_pkg.sv
// Shared types and constants of the text cell glyph renderer.
package tcg_pkg;

   localparam int FONT_DEPTH = 2048;
   localparam int FONT_AW    = 11;
   localparam int FONT_DW    = 8;
   localparam int CODE_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int ADDR_W     = 16;
   localparam int PIX_W      = 32;
   localparam int MAX_PIX    = 8;
   localparam int INDEX_W    = 4;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_RENDER = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RENDER
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;
      logic load;
      logic rd;
      logic emit;
      logic last_line;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic line_ready;
      logic room_if_emit;
      logic room_no_emit;
      logic out_free;
   } status_type;

endpackage

>>> hw/rtl/tcg_if.sv
// Handshake channel interfaces for the request and response words.
interface tcg_req_if
   import tcg_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [FONT_AW-1:0]   font_address;
   logic [FONT_DW-1:0]   font_byte;
   logic [CODE_W-1:0]    char_code;
   logic [ATTR_W-1:0]    attribute;

   modport source (output valid, action, font_address, font_byte, char_code, attribute,
                   input ready);
   modport sink   (input valid, action, font_address, font_byte, char_code, attribute,
                   output ready);
endinterface

interface tcg_rsp_if
   import tcg_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    byte_address;
   logic [PIX_W-1:0]     row_pixels;
   logic                 last_of_cell;
   logic                 last_of_screen;

   modport source (output valid, byte_address, row_pixels, last_of_cell, last_of_screen,
                   input ready);
   modport sink   (input valid, byte_address, row_pixels, last_of_cell, last_of_screen,
                   output ready);
endinterface

>>> hw/rtl/text_cell_glyph_renderer_top.sv
// Top level of the text cell glyph renderer.
//
// This block paints a SCREEN_COLUMNS x SCREEN_ROWS text screen into a packed
// 4-bit indexed bitmap, two pixels per byte with the left pixel in the high
// nibble. A request word with action 0 writes one byte of the 2048-byte font
// store and produces no response. A request word with
// action 1 renders the next character cell: the glyph of char_code is drawn
// with the attribute's low nibble as foreground and bits 6:4 as background,
// and GLYPH_HEIGHT response words come out, one per glyph line, each carrying
// the bitmap byte address of that line, the pixel indices (leftmost pixel in
// the most significant used nibble, only the rightmost eight pixels when the
// glyph is wider), and flags for the last line of the cell and of the screen.
// The cell position advances column by column, then row by row, and wraps to
// the top left after the last cell. The font store has one read port that
// delivers one glyph byte per cycle while the glyph bit buffer has room,
// and a line leaves as soon as enough glyph bits have arrived and the
// response register is free. One cell is in work at a time; the last line
// may still wait in the response register while the next request word is
// taken. Font bytes must be written before a glyph that uses them is
// rendered.
module text_cell_glyph_renderer_top
   import tcg_pkg::*;
#(
   parameter int GLYPH_WIDTH    = 8,
   parameter int GLYPH_HEIGHT   = 8,
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcg_req_if.sink    req_bus,
   tcg_rsp_if.source  rsp_bus
);

   // Command and status between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // The controller decides when each font byte is read and when each glyph
   // line is handed to the response register.
   tcg_ctrl #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the font store, the glyph bit buffer, the cell
   // position counters and the response register.
   tcg_datapath #(
      .GLYPH_WIDTH    (GLYPH_WIDTH),
      .GLYPH_HEIGHT   (GLYPH_HEIGHT),
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .font_address       (req_bus.font_address),
      .font_byte          (req_bus.font_byte),
      .char_code          (req_bus.char_code),
      .attribute          (req_bus.attribute),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_byte_address   (rsp_bus.byte_address),
      .rsp_row_pixels     (rsp_bus.row_pixels),
      .rsp_last_of_cell   (rsp_bus.last_of_cell),
      .rsp_last_of_screen (rsp_bus.last_of_screen)
   );

endmodule

>>> hw/rtl/tcg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tcg_ctrl.sv
// Controller: issues font writes, sequences a cell's reads and line emission.
module tcg_ctrl
   import tcg_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NBYTES = (GLYPH_WIDTH * GLYPH_HEIGHT + 7) / 8;
   localparam int LW     = $clog2(GLYPH_HEIGHT + 1);
   localparam int BW     = $clog2(NBYTES + 1);

   state_type         state_ff, state_in;
   logic [LW-1:0]     lines_left_ff, lines_left_in;
   logic [BW-1:0]     bytes_left_ff, bytes_left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lines_left_ff <= '0;
         bytes_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         lines_left_ff <= lines_left_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      lines_left_in = lines_left_ff;
      bytes_left_in = bytes_left_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACTION_RENDER) begin
                  cmd.start     = 1'b1;
                  lines_left_in = LW'(GLYPH_HEIGHT);
                  bytes_left_in = BW'(NBYTES);
                  state_in      = ST_RENDER;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_RENDER: begin
            cmd.last_line = (lines_left_ff == LW'(1));
            cmd.emit      = (lines_left_ff != '0) && status.line_ready && status.out_free;
            cmd.rd        = (bytes_left_ff != '0) &&
                            (cmd.emit ? status.room_if_emit : status.room_no_emit);
            if (cmd.rd) begin
               bytes_left_in = bytes_left_ff - BW'(1);
            end
            if (cmd.emit) begin
               lines_left_in = lines_left_ff - LW'(1);
               if (cmd.last_line) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/tcg_datapath.sv
// Datapath: font store, glyph bit buffer, cell counters and response register.
module tcg_datapath
   import tcg_pkg::*;
#(
   parameter int GLYPH_WIDTH    = 8,
   parameter int GLYPH_HEIGHT   = 8,
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [FONT_AW-1:0]  font_address,
   input  logic [FONT_DW-1:0]  font_byte,
   input  logic [CODE_W-1:0]   char_code,
   input  logic [ATTR_W-1:0]   attribute,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_byte_address,
   output logic [PIX_W-1:0]    rsp_row_pixels,
   output logic                rsp_last_of_cell,
   output logic                rsp_last_of_screen
);

   localparam int BUF_W  = GLYPH_WIDTH + 7;
   localparam int FILL_W = $clog2(BUF_W + 1);

   localparam logic [FONT_AW-1:0] GLYPH_BYTES = FONT_AW'(GLYPH_WIDTH * GLYPH_HEIGHT / 8);
   localparam logic [ADDR_W-1:0]  LINE_PITCH  = ADDR_W'(GLYPH_WIDTH * SCREEN_COLUMNS / 2);
   localparam logic [ADDR_W-1:0]  ROW_PITCH   =
      ADDR_W'(GLYPH_WIDTH * SCREEN_COLUMNS / 2 * GLYPH_HEIGHT);
   localparam logic [ADDR_W-1:0]  COL_STEP    = ADDR_W'(GLYPH_WIDTH / 2);
   localparam logic [COL_W-1:0]   COL_LAST    = COL_W'(SCREEN_COLUMNS - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [FILL_W:0]    W_CMP       = (FILL_W + 1)'(GLYPH_WIDTH);
   localparam logic [FILL_W:0]    TWO_W_CMP   = (FILL_W + 1)'(2 * GLYPH_WIDTH);

   // Font store and read pipeline.
   logic [FONT_DW-1:0] rd_data;
   logic [FONT_AW-1:0] rd_addr_ff;
   logic               rd_pending_ff;

   tcg_ram #(.WIDTH(FONT_DW), .DEPTH(FONT_DEPTH)) u_font_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (font_address),
      .wr_data (font_byte),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // Glyph bit buffer, LSB is the next glyph bit.
   logic [BUF_W-1:0]  bits_ff, bits_in, cur_bits;
   logic [FILL_W-1:0] fill_ff, fill_in, cur_fill;

   // Per-cell attributes and addressing.
   logic [INDEX_W-1:0] fg_ff;
   logic [2:0]         bg_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               last_cell_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [ADDR_W-1:0]  col_off_ff;
   logic [ADDR_W-1:0]  row_base_ff;
   logic               col_last, row_last;

   // Response register.
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [PIX_W-1:0]   rsp_pix_ff;
   logic               rsp_loc_ff;
   logic               rsp_los_ff;
   logic [PIX_W-1:0]   line_pix;
   logic [GLYPH_WIDTH-1:0] line_bits;

   assign cur_bits = bits_ff | (rd_pending_ff ? (BUF_W'(rd_data) << fill_ff) : '0);
   assign cur_fill = fill_ff + (rd_pending_ff ? FILL_W'(FONT_DW) : '0);
   assign line_bits = cur_bits[GLYPH_WIDTH-1:0];

   always_comb begin
      if (cmd.start) begin
         bits_in = '0;
         fill_in = '0;
      end else if (cmd.emit) begin
         bits_in = cur_bits >> GLYPH_WIDTH;
         fill_in = cur_fill - FILL_W'(GLYPH_WIDTH);
      end else begin
         bits_in = cur_bits;
         fill_in = cur_fill;
      end
   end

   assign status.line_ready   = ({1'b0, cur_fill} >= W_CMP);
   assign status.room_if_emit = ({1'b0, cur_fill} <  TWO_W_CMP);
   assign status.room_no_emit = ({1'b0, cur_fill} <  W_CMP);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   // The rightmost pixels of the line land in the low nibbles.
   for (genvar j = 0; j < MAX_PIX; j++) begin : g_pix
      if (j < GLYPH_WIDTH) begin : g_used
         assign line_pix[INDEX_W*j +: INDEX_W] =
            line_bits[GLYPH_WIDTH-1-j] ? fg_ff : {1'b0, bg_ff};
      end else begin : g_unused
         assign line_pix[INDEX_W*j +: INDEX_W] = '0;
      end
   end

   assign col_last = (col_ff == COL_LAST);
   assign row_last = (row_ff == ROW_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pending_ff <= 1'b0;
         fill_ff       <= '0;
         bits_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         col_off_ff    <= '0;
         row_base_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_pending_ff <= cmd.rd;
         fill_ff       <= fill_in;
         bits_ff       <= bits_in;
         if (cmd.start) begin
            if (col_last) begin
               col_ff     <= '0;
               col_off_ff <= '0;
               if (row_last) begin
                  row_ff      <= '0;
                  row_base_ff <= '0;
               end else begin
                  row_ff      <= row_ff + ROW_W'(1);
                  row_base_ff <= row_base_ff + ROW_PITCH;
               end
            end else begin
               col_ff     <= col_ff + COL_W'(1);
               col_off_ff <= col_off_ff + COL_STEP;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_addr_ff   <= {{(FONT_AW-CODE_W){1'b0}}, char_code} * GLYPH_BYTES;
         fg_ff        <= attribute[3:0];
         bg_ff        <= attribute[6:4];
         addr_ff      <= row_base_ff + col_off_ff;
         last_cell_ff <= col_last && row_last;
      end else begin
         if (cmd.rd) begin
            rd_addr_ff <= rd_addr_ff + FONT_AW'(1);
         end
         if (cmd.emit) begin
            addr_ff <= addr_ff + LINE_PITCH;
         end
      end
      if (cmd.emit) begin
         rsp_addr_ff <= addr_ff;
         rsp_pix_ff  <= line_pix;
         rsp_loc_ff  <= cmd.last_line;
         rsp_los_ff  <= cmd.last_line && last_cell_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_address   = rsp_addr_ff;
   assign rsp_row_pixels     = rsp_pix_ff;
   assign rsp_last_of_cell   = rsp_loc_ff;
   assign rsp_last_of_screen = rsp_los_ff;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the text cell glyph renderer top level.
module tb_top
   import tcg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The block is built with its default geometry: 8x8 glyphs on an 80x25 screen.
   localparam int GLYPH_WIDTH    = 8;
   localparam int GLYPH_HEIGHT   = 8;
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;

   // Bytes per glyph and bitmap bytes per pixel line of the whole screen.
   localparam int GLYPH_BYTES = GLYPH_WIDTH * GLYPH_HEIGHT / 8;
   localparam int LINE_PITCH  = GLYPH_WIDTH * SCREEN_COLUMNS / 2;

   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_WORDS    = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   // The limit leaves a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT     = 1000000;

   typedef struct {
      logic                 action;
      logic [FONT_AW-1:0]   font_address;
      logic [FONT_DW-1:0]   font_byte;
      logic [CODE_W-1:0]    char_code;
      logic [ATTR_W-1:0]    attribute;
   } request_word_type;

   typedef struct {
      logic [ADDR_W-1:0]    byte_address;
      logic [PIX_W-1:0]     row_pixels;
      logic                 last_of_cell;
      logic                 last_of_screen;
   } glyph_row_type;

   // The tracker keeps its own copy of the font store and of the cell position.
   // Every accepted render word is turned into the glyph rows the block owes,
   // and every response word is checked against the oldest row still owed.
   class glyph_row_tracker;
      logic [FONT_DW-1:0] font_copy [FONT_DEPTH];
      int                 cell_column;
      int                 cell_row;
      int                 mismatches;
      glyph_row_type      rows_due [$];

      function new();
         cell_column     = 0;
         cell_row        = 0;
         mismatches      = 0;
      endfunction

      function void note_word(request_word_type w);
         glyph_row_type      row;
         logic [PIX_W-1:0]   pixels;
         logic [INDEX_W-1:0] fg;
         logic [INDEX_W-1:0] bg;
         logic [FONT_DW-1:0] glyph_byte;
         int                 base;
         int                 bit_index;
         int                 cell_base;
         bit                 last_cell;
         if (w.action == ACTION_LOAD) begin
            font_copy[w.font_address] = w.font_byte;
            return;
         end
         // Bit 7 of the attribute plays no part in the colors.
         fg = w.attribute[3:0];
         bg = {1'b0, w.attribute[6:4]};
         base = w.char_code * GLYPH_BYTES;
         cell_base = cell_row * LINE_PITCH * GLYPH_HEIGHT + cell_column * (GLYPH_WIDTH / 2);
         last_cell = (cell_column + 1 >= SCREEN_COLUMNS) && (cell_row + 1 >= SCREEN_ROWS);
         for (int line = 0; line < GLYPH_HEIGHT; line++) begin
            pixels = '0;
            // Glyph bits run on through the glyph, LSB first within each byte.
            // Shifting left keeps only the rightmost pixels of a wide glyph.
            for (int x = 0; x < GLYPH_WIDTH; x++) begin
               bit_index = line * GLYPH_WIDTH + x;
               glyph_byte = font_copy[(base + bit_index / 8) % FONT_DEPTH];
               pixels = {pixels[PIX_W-INDEX_W-1:0], glyph_byte[bit_index % 8] ? fg : bg};
            end
            row.byte_address   = ADDR_W'(cell_base + line * LINE_PITCH);
            row.row_pixels     = pixels;
            row.last_of_cell   = (line == GLYPH_HEIGHT - 1);
            row.last_of_screen = (line == GLYPH_HEIGHT - 1) && last_cell;
            rows_due.push_back(row);
         end
         if (cell_column + 1 >= SCREEN_COLUMNS) begin
            cell_column = 0;
            cell_row = (cell_row + 1 >= SCREEN_ROWS) ? 0 : cell_row + 1;
         end else begin
            cell_column++;
         end
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_row(glyph_row_type got);
         glyph_row_type want;
         if (rows_due.size() == 0) begin
            mismatches++;
            $error("unexpected glyph row at byte_address 0x%0h", got.byte_address);
            return;
         end
         want = rows_due.pop_front();
         compare("byte_address", 32'(want.byte_address), 32'(got.byte_address));
         compare("row_pixels", want.row_pixels, got.row_pixels);
         compare("last_of_cell", 32'(want.last_of_cell), 32'(got.last_of_cell));
         compare("last_of_screen", 32'(want.last_of_screen), 32'(got.last_of_screen));
      endfunction
   endclass

   logic clock;
   logic reset;

   tcg_req_if req_bus ();
   tcg_rsp_if rsp_bus ();

   text_cell_glyph_renderer_top #(
      .GLYPH_WIDTH    (GLYPH_WIDTH),
      .GLYPH_HEIGHT   (GLYPH_HEIGHT),
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   glyph_row_tracker tracker;

   // The stimulus side keeps track of which font bytes hold data, so that no
   // glyph is rendered before all of its bytes have been written.
   bit font_written [FONT_DEPTH];
   bit code_listed [FONT_DEPTH];
   int ready_codes [$];
   int words_sent;
   int cycle_count;

   // Each side switches now and then between random gaps and a calm stretch
   // with no gaps at all.
   bit send_calm;
   bit take_calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a run that hangs ends here as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Offers one request word after a random gap and waits until it is taken.
   // Valid stays high from one word to the next when no gap is drawn.
   task automatic send_word(request_word_type w);
      int gap;
      int code;
      bit complete;
      if ($urandom_range(0, 31) == 0) begin
         send_calm = !send_calm;
      end
      gap = send_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= w.action;
      req_bus.font_address <= w.font_address;
      req_bus.font_byte    <= w.font_byte;
      req_bus.char_code    <= w.char_code;
      req_bus.attribute    <= w.attribute;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_word(w);
      words_sent++;
      // A load may complete a glyph; from then on that code can be rendered.
      if (w.action == ACTION_LOAD) begin
         font_written[w.font_address] = 1'b1;
         code = w.font_address / GLYPH_BYTES;
         complete = !code_listed[code];
         for (int k = 0; k < GLYPH_BYTES; k++) begin
            if (!font_written[(code * GLYPH_BYTES + k) % FONT_DEPTH]) begin
               complete = 1'b0;
            end
         end
         if (complete) begin
            code_listed[code] = 1'b1;
            ready_codes.push_back(code);
         end
      end
   endtask

   // The render fields of a load word carry random values; the block ignores them.
   task automatic load_font(int address, int value);
      request_word_type w;
      w.action       = ACTION_LOAD;
      w.font_address = FONT_AW'(address);
      w.font_byte    = FONT_DW'(value);
      w.char_code    = CODE_W'($urandom_range(0, 255));
      w.attribute    = ATTR_W'($urandom_range(0, 255));
      send_word(w);
   endtask

   // Likewise the load fields of a render word carry random values.
   task automatic render_cell(int code, int attr);
      request_word_type w;
      w.action       = ACTION_RENDER;
      w.font_address = FONT_AW'($urandom_range(0, FONT_DEPTH - 1));
      w.font_byte    = FONT_DW'($urandom_range(0, 255));
      w.char_code    = CODE_W'(code);
      w.attribute    = ATTR_W'(attr);
      send_word(w);
   endtask

   // Takes response words after random gaps. Twice in the run the ready line
   // is held low for a long stretch, so the block fills up and has to stall
   // its request side while the sender keeps offering words.
   task automatic take_rows();
      int gap;
      int rows_taken;
      glyph_row_type got;
      rows_taken = 0;
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            take_calm = !take_calm;
         end
         gap = take_calm ? 0 : $urandom_range(0, 4);
         if (rows_taken == 200 || rows_taken == 600) begin
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.byte_address   = rsp_bus.byte_address;
         got.row_pixels     = rsp_bus.row_pixels;
         got.last_of_cell   = rsp_bus.last_of_cell;
         got.last_of_screen = rsp_bus.last_of_screen;
         tracker.check_row(got);
         rows_taken++;
      end
   endtask

   initial begin
      int kind;
      int code;
      int count;
      int first;
      tracker = new();
      words_sent = 0;
      send_calm = 1'b0;
      take_calm = 1'b0;

      // Every input starts at a known value while reset is held.
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACTION_LOAD;
      req_bus.font_address <= '0;
      req_bus.font_byte    <= '0;
      req_bus.char_code    <= '0;
      req_bus.attribute    <= '0;
      rsp_bus.ready        <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      fork
         take_rows();
      join_none

      // Directed part. The glyphs of the lowest and the highest code are
      // written with edge patterns; the highest reaches the last font byte.
      load_font(0, 8'h00);
      load_font(1, 8'hFF);
      load_font(2, 8'h01);
      load_font(3, 8'h80);
      load_font(4, 8'hAA);
      load_font(5, 8'h55);
      load_font(6, 8'h0F);
      load_font(7, 8'hF0);
      load_font(255 * GLYPH_BYTES + 0, 8'hFF);
      load_font(255 * GLYPH_BYTES + 1, 8'h00);
      load_font(255 * GLYPH_BYTES + 2, 8'h7E);
      load_font(255 * GLYPH_BYTES + 3, 8'h81);
      load_font(255 * GLYPH_BYTES + 4, 8'hC3);
      load_font(255 * GLYPH_BYTES + 5, 8'h3C);
      load_font(255 * GLYPH_BYTES + 6, 8'h18);
      load_font(FONT_DEPTH - 1, 8'hE7);
      // Renders with all-zero and all-one attributes, the ignored top bit set
      // alone, the largest colors without it, and a mixed pair of colors.
      render_cell(0, 8'h00);
      render_cell(0, 8'hFF);
      render_cell(255, 8'h7F);
      render_cell(255, 8'h80);
      render_cell(0, 8'h5A);

      // Random part. Most of it renders glyphs that are known to be written or
      // writes a whole glyph and renders it; the rest is stray font writes and
      // glyphs left half written.
      while (words_sent < RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            render_cell(ready_codes[$urandom_range(0, ready_codes.size() - 1)],
                        $urandom_range(0, 255));
         end else if (kind < 80) begin
            code = $urandom_range(0, 255);
            for (int k = 0; k < GLYPH_BYTES; k++) begin
               load_font(code * GLYPH_BYTES + k, $urandom_range(0, 255));
            end
            render_cell(code, $urandom_range(0, 255));
         end else if (kind < 95) begin
            load_font($urandom_range(0, FONT_DEPTH - 1), $urandom_range(0, 255));
         end else begin
            code = $urandom_range(0, 255);
            count = $urandom_range(1, GLYPH_BYTES - 1);
            first = $urandom_range(0, GLYPH_BYTES - count);
            for (int k = 0; k < count; k++) begin
               load_font(code * GLYPH_BYTES + first + k, $urandom_range(0, 255));
            end
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for every owed row, then keep watching to catch stray words.
      while (tracker.rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
